>>> hdl/tw_pkg.sv
package tw_pkg;

    localparam int SAMPLES     = 128;
    localparam int CODE_W      = 12;
    localparam int PH_W        = $clog2(SAMPLES);
    localparam int CNT_W       = 16;
    localparam int DUTY_W      = 7;
    localparam int WT_W        = 2;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int SINE_W      = 15;
    localparam int ATT_W       = CODE_W - 1;
    localparam int SPROD_W     = ATT_W + SINE_W;
    localparam int A_W         = $clog2(SAMPLES + 1);
    localparam int MAX_M       = ((1 << DUTY_W) - 1) * SAMPLES / 100;
    localparam int M_W         = $clog2(MAX_M + 1);
    localparam int NUM_W       = CODE_W + PH_W;
    localparam int QCNT_W      = $clog2(NUM_W + 1);
    localparam int STATE_DEPTH = 2;
    localparam int STATE_AW    = $clog2(STATE_DEPTH);
    localparam logic [CODE_W-1:0] CODE_MAX = CODE_W'((1 << CODE_W) - 1);

    localparam logic [CFG_IDX_W-1:0] REG_WAVE_TYPE    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_BOTTOM_CODE  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_TOP_CODE     = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_DUTY_PERCENT = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_CYCLE_LIMIT  = CFG_IDX_W'(4);

    typedef enum logic [WT_W-1:0] {
        WAVE_NONE     = 2'd0,
        WAVE_SINE     = 2'd1,
        WAVE_SQUARE   = 2'd2,
        WAVE_TRIANGLE = 2'd3
    } t_wave;

    typedef struct packed {
        logic              halted;
        logic [CODE_W-1:0] held_code;
        logic [CNT_W-1:0]  period_count;
        logic [PH_W-1:0]   phase_index;
    } t_state;

    localparam int STATE_W = $bits(t_state);

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [PH_W-1:0]  den;
    } t_div_req;

    typedef struct packed {
        logic             busy;
        logic [NUM_W-1:0] quot;
    } t_div_rsp;

    typedef logic [SINE_W-1:0] t_sine_rom [0:SAMPLES];
    typedef logic [M_W-1:0]    t_duty_rom [0:(1 << DUTY_W)-1];

    localparam longint unsigned Q30_ONE = 64'd1 << 30;

    function automatic logic [SINE_W-1:0] sine_mag(input int unsigned a);
        longint unsigned pi_q30;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned s;
        pi_q30 = (64'd314159 << 30) / 64'd100000;
        x  = (longint'(a) * (pi_q30 / 64'd2)) / SAMPLES;
        x2 = (x * x) >> 30;
        t  = Q30_ONE;
        t  = Q30_ONE - (((x2 * t) >> 30) / 64'd110);
        t  = Q30_ONE - (((x2 * t) >> 30) / 64'd72);
        t  = Q30_ONE - (((x2 * t) >> 30) / 64'd42);
        t  = Q30_ONE - (((x2 * t) >> 30) / 64'd20);
        t  = Q30_ONE - (((x2 * t) >> 30) / 64'd6);
        s  = (x * t) >> 30;
        return SINE_W'((s * 64'd32767) >> 30);
    endfunction

    function automatic t_sine_rom build_sine_rom();
        t_sine_rom rom;
        for (int i = 0; i <= SAMPLES; i++) begin
            rom[i] = sine_mag(i);
        end
        return rom;
    endfunction

    function automatic t_duty_rom build_duty_rom();
        t_duty_rom rom;
        for (int i = 0; i < (1 << DUTY_W); i++) begin
            rom[i] = M_W'((i * SAMPLES) / 100);
        end
        return rom;
    endfunction

    localparam t_sine_rom SINE_ROM = build_sine_rom();
    localparam t_duty_rom DUTY_ROM = build_duty_rom();

endpackage

>>> hdl/tw_ram.sv
module tw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/tw_div.sv
module tw_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tw_pkg::t_div_req  i_req,
    output tw_pkg::t_div_rsp  o_rsp
);

    logic                      r_busy;
    logic [tw_pkg::QCNT_W-1:0] r_cnt;
    logic [tw_pkg::PH_W-1:0]   r_rem;
    logic [tw_pkg::PH_W-1:0]   r_den;
    logic [tw_pkg::NUM_W-1:0]  r_quot;
    logic [tw_pkg::PH_W:0]     rem_sh;
    logic [tw_pkg::PH_W:0]     diff;
    logic                      ge;

    assign rem_sh = {r_rem, r_quot[tw_pkg::NUM_W-1]};
    assign ge     = rem_sh >= {1'b0, r_den};
    assign diff   = rem_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_cnt  <= tw_pkg::QCNT_W'(tw_pkg::NUM_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - tw_pkg::QCNT_W'(1);
            if (r_cnt == tw_pkg::QCNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem  <= '0;
            r_den  <= i_req.den;
            r_quot <= i_req.num;
        end else if (r_busy) begin
            r_rem  <= ge ? diff[tw_pkg::PH_W-1:0] : rem_sh[tw_pkg::PH_W-1:0];
            r_quot <= {r_quot[tw_pkg::NUM_W-2:0], ge};
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.quot = r_quot;

endmodule

>>> hdl/table_waveform_generator_core.sv
// Table waveform generator: one 12-bit DAC code per sample transaction.
// Input channel (i_in_valid / o_in_stall) carries i_restart; each accepted
// transaction yields exactly one result on the output channel
// (o_out_valid / i_out_stall) with o_sample_code, o_period_end, o_stopped.
// Configuration registers are written over i_cfg_valid / o_cfg_ready with
// i_cfg_index and i_cfg_data; o_cfg_ready is always high and writes belong
// to idle periods between transactions.
// Sequence: an accepted input moves the sequencer through S_READ (state memory
// read), S_CALC, S_DIV and S_FIN, and the result is then registered; the next
// input is taken only back in S_IDLE, so one transaction is finished before the
// next is accepted. The bit-serial divider for the triangle slope runs CODE_W +
// PH_W steps in S_DIV, with the state memory read and write-back around it.
// Reset is synchronous; afterwards state S_CLEAR clears the state memory entry,
// with o_in_stall high, before the first transaction is taken.
// While the receiver stalls, the result is held in the output register; one
// further transaction may be taken and computed, and it then waits until the
// held result has been delivered.
module table_waveform_generator_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_restart,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [tw_pkg::CODE_W-1:0]     o_sample_code,
    output logic                          o_period_end,
    output logic                          o_stopped,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [tw_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tw_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_READ  = 6'b000100,
        S_CALC  = 6'b001000,
        S_DIV   = 6'b010000,
        S_FIN   = 6'b100000
    } t_fsm;

    t_fsm                           r_fsm;
    t_fsm                           n_fsm;

    tw_pkg::t_wave                  r_wave_type;
    logic [tw_pkg::CODE_W-1:0]      r_bottom;
    logic [tw_pkg::CODE_W-1:0]      r_top;
    logic [tw_pkg::DUTY_W-1:0]      r_duty;
    logic [tw_pkg::CNT_W-1:0]       r_limit;

    logic                           r_restart;
    tw_pkg::t_state                 r_st;
    tw_pkg::t_state                 n_st;
    tw_pkg::t_state                 rd_st;
    tw_pkg::t_state                 ld_st;
    tw_pkg::t_state                 wr_st;
    logic [tw_pkg::STATE_W-1:0]     ram_rdata;
    logic                           ram_we;
    logic                           in_acc;

    logic [tw_pkg::SPROD_W-1:0]     r_sprod;
    logic                           r_neg;
    logic                           r_rise;

    logic                           r_out_valid;
    logic [tw_pkg::CODE_W-1:0]      r_out_code;
    logic                           r_out_pend;
    logic                           r_out_stopped;
    logic                           out_free;

    logic [tw_pkg::CODE_W-1:0]      top_eff;
    logic [tw_pkg::CODE_W-1:0]      span;
    logic [tw_pkg::CODE_W-1:0]      mid;
    logic [tw_pkg::ATT_W-1:0]       att;
    logic [tw_pkg::M_W-1:0]         m_raw;
    logic [tw_pkg::PH_W-1:0]        m_tri;
    logic [tw_pkg::PH_W+2:0]        a4;
    logic [tw_pkg::PH_W+2:0]        a_fold;
    logic                           a_neg;
    logic [tw_pkg::ATT_W-1:0]       mag;
    logic [tw_pkg::CODE_W-1:0]      code;
    logic                           pend;
    logic [tw_pkg::CNT_W-1:0]       cnt_inc;

    tw_pkg::t_div_req               div_req;
    tw_pkg::t_div_rsp               div_rsp;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wave_type <= tw_pkg::WAVE_NONE;
            r_bottom    <= '0;
            r_top       <= '0;
            r_duty      <= tw_pkg::DUTY_W'(50);
            r_limit     <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                tw_pkg::REG_WAVE_TYPE: begin
                    r_wave_type <= tw_pkg::t_wave'(i_cfg_data[tw_pkg::WT_W-1:0]);
                end
                tw_pkg::REG_BOTTOM_CODE: begin
                    r_bottom <= i_cfg_data[tw_pkg::CODE_W-1:0];
                end
                tw_pkg::REG_TOP_CODE: begin
                    r_top <= i_cfg_data[tw_pkg::CODE_W-1:0];
                end
                tw_pkg::REG_DUTY_PERCENT: begin
                    r_duty <= i_cfg_data[tw_pkg::DUTY_W-1:0];
                end
                tw_pkg::REG_CYCLE_LIMIT: begin
                    r_limit <= i_cfg_data[tw_pkg::CNT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // state memory
    assign in_acc = i_in_valid && !o_in_stall;
    assign ram_we = (r_fsm == S_CLEAR) || ((r_fsm == S_FIN) && out_free);
    assign wr_st  = (r_fsm == S_CLEAR) ? '0 : n_st;
    assign rd_st  = tw_pkg::t_state'(ram_rdata);

    tw_ram #(
        .WIDTH (tw_pkg::STATE_W),
        .DEPTH (tw_pkg::STATE_DEPTH)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (tw_pkg::STATE_AW'(0)),
        .i_wdata (wr_st),
        .i_re    (in_acc),
        .i_raddr (tw_pkg::STATE_AW'(0)),
        .o_rdata (ram_rdata)
    );

    // restart clears the counters and the halted flag but keeps the held code
    always_comb begin
        ld_st = rd_st;
        if (r_restart) begin
            ld_st.phase_index  = '0;
            ld_st.period_count = '0;
            ld_st.halted       = 1'b0;
        end
    end

    // level and shape terms
    assign top_eff = (r_top < r_bottom) ? r_bottom : r_top;
    assign span    = top_eff - r_bottom;
    assign mid     = tw_pkg::CODE_W'(({1'b0, r_bottom} + {1'b0, top_eff}) >> 1);
    assign att     = span[tw_pkg::CODE_W-1:1];
    assign m_raw   = tw_pkg::DUTY_ROM[r_duty];

    always_comb begin
        if (m_raw == '0) begin
            m_tri = tw_pkg::PH_W'(1);
        end else if (m_raw > tw_pkg::M_W'(tw_pkg::SAMPLES - 1)) begin
            m_tri = tw_pkg::PH_W'(tw_pkg::SAMPLES - 1);
        end else begin
            m_tri = m_raw[tw_pkg::PH_W-1:0];
        end
    end

    // sine angle folding
    always_comb begin
        a4    = {1'b0, r_st.phase_index, 2'b00};
        a_neg = a4 >= (tw_pkg::PH_W+3)'(2 * tw_pkg::SAMPLES);
        a_fold = a_neg ? a4 - (tw_pkg::PH_W+3)'(2 * tw_pkg::SAMPLES) : a4;
        if (a_fold > (tw_pkg::PH_W+3)'(tw_pkg::SAMPLES)) begin
            a_fold = (tw_pkg::PH_W+3)'(2 * tw_pkg::SAMPLES) - a_fold;
        end
    end

    // triangle slope numerator and divisor
    always_comb begin
        div_req.start = (r_fsm == S_CALC);
        if (r_st.phase_index < m_tri) begin
            div_req.num = tw_pkg::NUM_W'(span) * tw_pkg::NUM_W'(r_st.phase_index);
            div_req.den = m_tri;
        end else begin
            div_req.num = tw_pkg::NUM_W'(span)
                        * tw_pkg::NUM_W'(r_st.phase_index - m_tri);
            div_req.den = tw_pkg::PH_W'(tw_pkg::SAMPLES) - m_tri;
        end
    end

    tw_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // code and state update
    assign mag = r_sprod[tw_pkg::SPROD_W-1:tw_pkg::SINE_W];

    always_comb begin
        case (r_wave_type)
            tw_pkg::WAVE_SINE: begin
                code = r_neg ? mid - tw_pkg::CODE_W'(mag) : mid + tw_pkg::CODE_W'(mag);
            end
            tw_pkg::WAVE_SQUARE: begin
                code = (tw_pkg::M_W'(r_st.phase_index) < m_raw) ? top_eff : r_bottom;
            end
            tw_pkg::WAVE_TRIANGLE: begin
                code = r_rise ? r_bottom + div_rsp.quot[tw_pkg::CODE_W-1:0]
                              : top_eff - div_rsp.quot[tw_pkg::CODE_W-1:0];
            end
            default: begin
                code = tw_pkg::CODE_MAX;
            end
        endcase
    end

    assign cnt_inc = (r_st.period_count == '1) ? r_st.period_count
                                               : r_st.period_count + tw_pkg::CNT_W'(1);

    always_comb begin
        n_st = r_st;
        pend = 1'b0;
        if (!r_st.halted) begin
            n_st.held_code = code;
            if (r_st.phase_index == tw_pkg::PH_W'(tw_pkg::SAMPLES - 1)) begin
                pend = 1'b1;
                n_st.phase_index = '0;
                if (r_limit != '0) begin
                    n_st.period_count = cnt_inc;
                    n_st.halted       = cnt_inc >= r_limit;
                end
            end else begin
                n_st.phase_index = r_st.phase_index + tw_pkg::PH_W'(1);
            end
        end
    end

    // sequencer
    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_fsm != S_IDLE);

    always_comb begin
        n_fsm = r_fsm;
        unique case (r_fsm)
            S_CLEAR: n_fsm = S_IDLE;
            S_IDLE:  n_fsm = in_acc ? S_READ : S_IDLE;
            S_READ:  n_fsm = S_CALC;
            S_CALC:  n_fsm = S_DIV;
            S_DIV:   n_fsm = div_rsp.busy ? S_DIV : S_FIN;
            S_FIN:   n_fsm = out_free ? S_IDLE : S_FIN;
            default: n_fsm = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm <= S_CLEAR;
        end else begin
            r_fsm <= n_fsm;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_restart <= i_restart;
        end
        if (r_fsm == S_READ) begin
            r_st <= ld_st;
        end
        if (r_fsm == S_CALC) begin
            r_sprod <= tw_pkg::SPROD_W'(att)
                     * tw_pkg::SPROD_W'(tw_pkg::SINE_ROM[a_fold[tw_pkg::A_W-1:0]]);
            r_neg   <= a_neg;
            r_rise  <= r_st.phase_index < m_tri;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_fsm == S_FIN) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_fsm == S_FIN) && out_free) begin
            r_out_code    <= r_st.halted ? r_st.held_code : code;
            r_out_pend    <= pend;
            r_out_stopped <= n_st.halted;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_sample_code = r_out_code;
    assign o_period_end  = r_out_pend;
    assign o_stopped     = r_out_stopped;

endmodule

>>> hdl/tw_checker.sv
module tw_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      o_in_stall,
    input logic                      o_out_valid,
    input logic                      i_out_stall,
    input logic [tw_pkg::CODE_W-1:0] o_sample_code,
    input logic                      o_period_end,
    input logic                      o_stopped
);

    // one transaction in flight at a time
    a_in_then_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken while a transaction is in flight");

    a_no_out_after_reset : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !o_out_valid)
        else $error("result offered straight after reset");

    a_out_known : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !$isunknown({o_sample_code, o_period_end, o_stopped}))
        else $error("result fields unknown while valid");

    a_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_sample_code)
            && $stable(o_period_end) && $stable(o_stopped)))
        else $error("stalled result changed");

endmodule

bind table_waveform_generator_core tw_checker u_tw_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_sample_code (o_sample_code),
    .o_period_end  (o_period_end),
    .o_stopped     (o_stopped)
);
